[src/conv_pkg.sv]
// ----------------------------------------------------------------------------
// conv_pkg
// Shared types and constants for the 3x3 convolution block: item structs,
// configuration register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package conv_pkg;

  // Geometry limits (defaults for the top-level parameters)
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Configuration register widths and reset values
  localparam int SIZE_W = 11;
  localparam int COEF_ROW_W = 24;
  localparam logic [SIZE_W-1:0]     WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0]     HEIGHT_RST = 11'd480;
  localparam logic [COEF_ROW_W-1:0] TOP_RST    = 24'h000000;
  localparam logic [COEF_ROW_W-1:0] MIDDLE_RST = 24'h01FF00;
  localparam logic [COEF_ROW_W-1:0] BOTTOM_RST = 24'h000000;

  // Smallest legal line length and frame height
  localparam int MIN_SIZE = 3;

  // Datapath widths: one product, one column product sum, and the full window sum
  localparam int PROD_W = 17;
  localparam int PART_W = 19;
  localparam int SUM_W  = 21;
  localparam logic [7:0] PIX_MAX = 8'hFF;

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_COEF_TOP     = 3'd2,
    CFG_COEF_MIDDLE  = 3'd3,
    CFG_COEF_BOTTOM  = 3'd4
  } cfg_reg_t;

  // Input and output items
  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_of_frame;
  } out_item_t;

  // Window column: [0] top line, [1] middle line, [2] newest line
  typedef logic [2:0][7:0] pix_col_t;
  // Coefficient column, same row order, each byte signed
  typedef logic [2:0][7:0] coef_col_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic       has_result;
    logic       last;
    logic [7:0] pix;
  } stage_meta_t;

endpackage

[src/conv3x3_abs_clamp.sv]
// ----------------------------------------------------------------------------
// conv3x3_abs_clamp
// 3x3 convolution of an 8-bit grayscale raster stream with |sum| clamped
// to 255; one result per interior pixel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and keeps that pace indefinitely while the output
// side keeps taking results. Each pixel passes through the line store read,
// window shift, column sums in the three window cells, then the final add,
// absolute value and clamp into an eight-entry result queue. The input stalls
// only when that queue plus the results still in the pipeline already fill it.
// Border positions produce no item. Line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module conv3x3_abs_clamp #(
  parameter int MAX_WIDTH  = conv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = conv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  conv_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output conv_pkg::out_item_t                  out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [conv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [conv_pkg::COEF_ROW_W-1:0]      cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // Configuration registers
  logic [conv_pkg::SIZE_W-1:0]     image_width;
  logic [conv_pkg::SIZE_W-1:0]     image_height;
  logic [conv_pkg::COEF_ROW_W-1:0] coef_top_row;
  logic [conv_pkg::COEF_ROW_W-1:0] coef_middle_row;
  logic [conv_pkg::COEF_ROW_W-1:0] coef_bottom_row;

  // Position counters
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;

  // Per-item position logic
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [CW-1:0] col_start;
  logic [RW-1:0] row_start;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_wrap;
  logic [RW-1:0] row_cur;
  logic          accept;
  logic          has_result;
  logic          is_last;

  // Pipeline
  logic                  v1, v2, v3;
  conv_pkg::stage_meta_t meta1, meta2, meta3;
  logic [AW-1:0]         col1;
  logic [7:0]            top_pix;
  logic [7:0]            mid_pix;

  // Window cells: index 2 holds the newest column
  conv_pkg::pix_col_t                 cell_in   [3];
  conv_pkg::pix_col_t                 cell_out  [3];
  conv_pkg::coef_col_t                cell_coef [3];
  logic signed [conv_pkg::PART_W-1:0] cell_part [3];

  // Final sum
  logic signed [conv_pkg::SUM_W-1:0] total;
  logic signed [conv_pkg::SUM_W-1:0] mag;
  conv_pkg::out_item_t               push_item;
  logic                              push;
  logic [conv_pkg::FIFO_CW-1:0]      fifo_count;
  logic [1:0]                        inflight;
  logic [conv_pkg::FIFO_CW:0]        used;

  // Configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= conv_pkg::WIDTH_RST;
      image_height    <= conv_pkg::HEIGHT_RST;
      coef_top_row    <= conv_pkg::TOP_RST;
      coef_middle_row <= conv_pkg::MIDDLE_RST;
      coef_bottom_row <= conv_pkg::BOTTOM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        conv_pkg::CFG_IMAGE_WIDTH:  image_width     <= cfg_data[conv_pkg::SIZE_W-1:0];
        conv_pkg::CFG_IMAGE_HEIGHT: image_height    <= cfg_data[conv_pkg::SIZE_W-1:0];
        conv_pkg::CFG_COEF_TOP:     coef_top_row    <= cfg_data;
        conv_pkg::CFG_COEF_MIDDLE:  coef_middle_row <= cfg_data;
        conv_pkg::CFG_COEF_BOTTOM:  coef_bottom_row <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp geometry to the supported range
  always_comb begin
    if (32'(image_width) < 32'(conv_pkg::MIN_SIZE)) begin
      w_eff = CW'(conv_pkg::MIN_SIZE);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
    if (32'(image_height) < 32'(conv_pkg::MIN_SIZE)) begin
      h_eff = RW'(conv_pkg::MIN_SIZE);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(image_height);
    end
  end

  // Position of the incoming pixel: frame restart, line wrap, frame wrap
  always_comb begin
    col_start = in_item.frame_start ? '0 : col_cnt;
    row_start = in_item.frame_start ? '0 : row_cnt;
    if (col_start >= w_eff) begin
      col_cur  = '0;
      row_wrap = row_start + 1'b1;
    end else begin
      col_cur  = col_start;
      row_wrap = row_start;
    end
    row_cur    = (row_wrap >= h_eff) ? '0 : row_wrap;
    has_result = (col_cur >= CW'(2)) && (row_cur >= RW'(2));
    is_last    = (col_cur == w_eff - 1'b1) && (row_cur == h_eff - 1'b1);
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_cur + 1'b1;
      row_cnt <= row_cur;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    meta1.has_result <= has_result;
    meta1.last       <= is_last;
    meta1.pix        <= in_item.pixel_in;
    col1             <= col_cur[AW-1:0];
    meta2            <= meta1;
    meta3            <= meta2;
  end

  // Line stores
  conv_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(col_cur[AW-1:0]),
    .wr_en  (v1),
    .wr_addr(col1),
    .wr_pix (meta1.pix),
    .top    (top_pix),
    .mid    (mid_pix)
  );

  // Chain of window cells
  assign cell_in[2] = {meta1.pix, mid_pix, top_pix};
  assign cell_in[1] = cell_out[2];
  assign cell_in[0] = cell_out[1];

  for (genvar c = 0; c < 3; c++) begin : g_cell
    assign cell_coef[c] = {coef_bottom_row[8*c +: 8], coef_middle_row[8*c +: 8],
                           coef_top_row[8*c +: 8]};
    conv_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (v1),
      .col_in (cell_in[c]),
      .coef   (cell_coef[c]),
      .col_out(cell_out[c]),
      .part   (cell_part[c])
    );
  end

  // Final add, absolute value, clamp
  always_comb begin
    total = conv_pkg::SUM_W'(cell_part[0]) + conv_pkg::SUM_W'(cell_part[1])
          + conv_pkg::SUM_W'(cell_part[2]);
    mag   = total[conv_pkg::SUM_W-1] ? -total : total;
    push_item.pixel_out     = (mag > conv_pkg::SUM_W'(conv_pkg::PIX_MAX)) ?
                              conv_pkg::PIX_MAX : mag[7:0];
    push_item.last_of_frame = meta3.last;
  end

  assign push = v3 && meta3.has_result;

  conv_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .count    (fifo_count)
  );

  // Credit check: queued plus in-flight results must leave room
  assign inflight = 2'(v1 && meta1.has_result) + 2'(v2 && meta2.has_result);
  assign used     = {1'b0, fifo_count} + (conv_pkg::FIFO_CW+1)'(inflight)
                  + (conv_pkg::FIFO_CW+1)'(v3 && meta3.has_result);
  assign in_ready = (used < (conv_pkg::FIFO_CW+1)'(conv_pkg::FIFO_DEPTH));

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < conv_pkg::FIFO_CW'(conv_pkg::FIFO_DEPTH)) || out_ready)
    else $error("result queue overflow");

  a_pipe_follow: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted item missing from first stage");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.frame_start) |=> (col_cnt == CW'(1)) && (row_cnt == '0))
    else $error("frame start did not restart position");

endmodule

[src/conv_line_buf.sv]
// ----------------------------------------------------------------------------
// conv_line_buf
// Two line stores holding the two previous image lines. Read one cycle after
// the address is given; the item then writes back the shifted column. A
// back-to-back revisit of the column being written is forwarded.
// ----------------------------------------------------------------------------
module conv_line_buf #(
  parameter int MAX_WIDTH = conv_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [7:0]                   wr_pix,
  output logic [7:0]                   top,
  output logic [7:0]                   mid
);

  logic [7:0] upper_mem [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];
  logic [7:0] rd_upper;
  logic [7:0] rd_middle;
  logic [7:0] last_upper;
  logic [7:0] last_middle;
  logic       hit;

  // Read data, forwarded from the write of the previous cycle on a hit
  assign top = hit ? last_upper : rd_upper;
  assign mid = hit ? last_middle : rd_middle;

  // Upper store: receives the column's old middle pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= mid;
    end
    if (rd_en) begin
      rd_upper <= upper_mem[rd_addr];
    end
  end

  // Middle store: receives the new pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      middle_mem[wr_addr] <= wr_pix;
    end
    if (rd_en) begin
      rd_middle <= middle_mem[rd_addr];
    end
  end

  // Copy of what was just written, for the forwarding path
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_upper  <= mid;
      last_middle <= wr_pix;
    end
  end

  // Read and write on the same column in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= rd_en && wr_en && (rd_addr == wr_addr);
    end
  end

endmodule

[src/conv_cell.sv]
// ----------------------------------------------------------------------------
// conv_cell
// One column of the 3x3 window. Holds three pixels, hands them to its left
// neighbor on every item and registers the column's weighted sum.
// ----------------------------------------------------------------------------
module conv_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               shift,
  input  conv_pkg::pix_col_t                 col_in,
  input  conv_pkg::coef_col_t                coef,
  output conv_pkg::pix_col_t                 col_out,
  output logic signed [conv_pkg::PART_W-1:0] part
);

  conv_pkg::pix_col_t                 col;
  logic signed [conv_pkg::PROD_W-1:0] prod [3];
  logic signed [conv_pkg::PART_W-1:0] part_next;

  assign col_out = col;

  // Pixel column, moves one place per item
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  // Three 9x8 signed products and their sum
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod[r] = conv_pkg::PROD_W'($signed({1'b0, col[r]}) * $signed(coef[r]));
    end
    part_next = conv_pkg::PART_W'(prod[0]) + conv_pkg::PART_W'(prod[1])
              + conv_pkg::PART_W'(prod[2]);
  end

  always_ff @(posedge clk) begin
    part <= part_next;
  end

endmodule

[src/conv_out_fifo.sv]
// ----------------------------------------------------------------------------
// conv_out_fifo
// Small result queue between the fixed-latency pipeline and the output
// channel. Its fill level feeds the input-side credit check.
// ----------------------------------------------------------------------------
module conv_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  conv_pkg::out_item_t          push_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output conv_pkg::out_item_t          out_item,
  output logic [conv_pkg::FIFO_CW-1:0] count
);

  conv_pkg::out_item_t              mem [conv_pkg::FIFO_DEPTH];
  logic [conv_pkg::FIFO_AW-1:0]     wr_ptr;
  logic [conv_pkg::FIFO_AW-1:0]     rd_ptr;
  logic                             pop;

  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
